// ===== design/echo_ranging_median_filter_defines.svh =====
// Assertion macros for the echo ranging median filter.
// Expects clk and arst_n in scope at the point of use; empty under SYNTHESIS.
`ifndef ECHO_RANGING_MEDIAN_FILTER_DEFINES_SVH
`define ECHO_RANGING_MEDIAN_FILTER_DEFINES_SVH

`ifndef SYNTHESIS
`define ERM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ERM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ERM_ASSERT_NOW(lbl, ante, cons)
`define ERM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== design/erm_pkg.sv =====
// Shared types and constants of the echo ranging median filter.
// No dependencies; imported by every module of the block but erm_ram.
`default_nettype none

package erm_pkg;

	localparam int US_W   = 15;
	localparam int DIST_W = 14;

	localparam int DEPTH_DEFAULT = 5;

	localparam logic [US_W-1:0] TRIG_LOW_TICKS  = 15'd4;
	localparam logic [US_W-1:0] TRIG_HIGH_TICKS = 15'd10;

	localparam logic [US_W-1:0] TIMEOUT_RESET   = 15'd20000;
	localparam logic [US_W-1:0] MIN_WIDTH_RESET = 15'd116;
	localparam logic [US_W-1:0] MAX_WIDTH_RESET = 15'd20300;

	// distance = (8 * width) / 29, by reciprocal: exact for every 18-bit numerator
	localparam int           CONV_NUM_W = US_W + 3;
	localparam int           RECIP_W    = 19;
	localparam int           RECIP_SH   = 23;
	localparam int           PROD_W     = CONV_NUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] DIST_RECIP = 19'd289263;

	localparam int ADDR_W = 4;
	localparam logic [1:0] REG_ECHO_TIMEOUT = 2'd0;
	localparam logic [1:0] REG_MIN_WIDTH    = 2'd1;
	localparam logic [1:0] REG_MAX_WIDTH    = 2'd2;

	typedef struct packed {
		logic start_req;
		logic echo;
	} tick_t;

	typedef struct packed {
		logic              trigger;
		logic              busy_res;
		logic              done_res;
		logic              accepted;
		logic [DIST_W-1:0] measured_distance;
		logic [DIST_W-1:0] filtered_distance;
		logic              filtered_valid;
	} result_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_TRIG_LOW,
		PH_TRIG_HIGH,
		PH_WAIT_RISE,
		PH_HIGH
	} phase_t;

	typedef enum logic [1:0] {
		SQ_READY,
		SQ_CONV,
		SQ_MED,
		SQ_EMIT
	} seq_state_t;

	typedef enum logic {
		MD_IDLE,
		MD_SCAN
	} med_state_t;

	// outcome of the current tick from the ranging state machine
	typedef struct packed {
		logic            trigger;
		logic            busy;
		logic            done;
		logic            measure;
		logic [US_W-1:0] width;
	} rng_out_t;

	typedef struct packed {
		logic              busy;
		logic              ok;
		logic [DIST_W-1:0] value;
	} med_status_t;

endpackage

`default_nettype wire

// ===== design/erm_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`default_nettype none

module erm_ram #(
	parameter int WIDTH = 14,
	parameter int DEPTH = 5,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr_a,
	output logic      [WIDTH-1:0] rdata_a,
	input  wire logic [AW-1:0]    raddr_b,
	output logic      [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_a_q;
	logic [WIDTH-1:0] rdata_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a_q <= mem_q[raddr_a];
		rdata_b_q <= mem_q[raddr_b];
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

`default_nettype wire

// ===== design/erm_ranger.sv =====
// Trigger and echo timing state machine, one step per accepted tick.
// Depends on erm_pkg.
`default_nettype none

module erm_ranger (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       step,
	input  wire erm_pkg::tick_t             tick,
	input  wire logic [erm_pkg::US_W-1:0]   timeout,
	output erm_pkg::rng_out_t               rng
);

	import erm_pkg::*;

	phase_t          phase_q, phase_d;
	logic [US_W-1:0] elapsed_q, elapsed_d;
	logic [US_W-1:0] elapsed_inc;

	assign elapsed_inc = elapsed_q + US_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			elapsed_q <= '0;
		end else if (step) begin
			phase_q   <= phase_d;
			elapsed_q <= elapsed_d;
		end
	end

	always_comb begin
		phase_d     = phase_q;
		elapsed_d   = elapsed_q;
		rng.trigger = 1'b0;
		rng.busy    = 1'b0;
		rng.done    = 1'b0;
		rng.measure = 1'b0;
		rng.width   = elapsed_q;
		case (phase_q)
			PH_IDLE: begin
				if (tick.start_req) begin
					phase_d   = PH_TRIG_LOW;
					elapsed_d = US_W'(1);
					rng.busy  = 1'b1;
				end
			end
			PH_TRIG_LOW: begin
				rng.busy  = 1'b1;
				elapsed_d = elapsed_inc;
				if (elapsed_inc >= TRIG_LOW_TICKS) begin
					phase_d   = PH_TRIG_HIGH;
					elapsed_d = '0;
				end
			end
			PH_TRIG_HIGH: begin
				rng.trigger = 1'b1;
				rng.busy    = 1'b1;
				elapsed_d   = elapsed_inc;
				if (elapsed_inc >= TRIG_HIGH_TICKS) begin
					phase_d   = PH_WAIT_RISE;
					elapsed_d = '0;
				end
			end
			PH_WAIT_RISE: begin
				if (tick.echo) begin
					if (timeout == '0) begin
						rng.done = 1'b1;
					end else begin
						phase_d   = PH_HIGH;
						elapsed_d = US_W'(1);
						rng.busy  = 1'b1;
					end
				end else if (elapsed_q >= timeout) begin
					rng.done = 1'b1;
				end else begin
					elapsed_d = elapsed_inc;
					rng.busy  = 1'b1;
				end
			end
			PH_HIGH: begin
				if (!tick.echo) begin
					rng.done    = 1'b1;
					rng.measure = 1'b1;
				end else if (elapsed_q >= timeout) begin
					rng.done = 1'b1;
				end else begin
					elapsed_d = elapsed_inc;
					rng.busy  = 1'b1;
				end
			end
			default: begin
				phase_d   = PH_IDLE;
				elapsed_d = '0;
			end
		endcase
		// any finish returns to idle
		if (rng.done) begin
			phase_d   = PH_IDLE;
			elapsed_d = '0;
		end
	end

endmodule

`default_nettype wire

// ===== design/erm_median.sv =====
// Sample ring; upper-median search on one shared compare pair.
// Depends on erm_pkg, erm_ram and the assertion macro header.
`default_nettype none
`include "echo_ranging_median_filter_defines.svh"

module erm_median #(
	parameter int DEPTH = erm_pkg::DEPTH_DEFAULT
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [erm_pkg::DIST_W-1:0]   sample,
	output erm_pkg::med_status_t              status
);

	import erm_pkg::*;

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	med_state_t        state_q, state_d;
	logic [IDX_W-1:0]  slot_q;
	logic [CNT_W-1:0]  fill_q;
	logic [IDX_W-1:0]  i_q, j_q;
	logic              rd_vld_s1, rd_last_s1;
	logic [CNT_W-1:0]  lt_cnt_q, le_cnt_q;
	logic [DIST_W-1:0] median_q;
	logic              ok_q;

	logic [DIST_W-1:0] cand, other;
	logic [CNT_W-1:0]  lt_sum, le_sum, rank;
	logic              j_last, i_last, found;

	erm_ram #(
		.WIDTH (DIST_W),
		.DEPTH (DEPTH),
		.AW    (IDX_W)
	) u_store (
		.clk     (clk),
		.we      (start),
		.waddr   (slot_q),
		.wdata   (sample),
		.raddr_a (i_q),
		.rdata_a (cand),
		.raddr_b (j_q),
		.rdata_b (other)
	);

	assign rank   = fill_q >> 1;
	assign j_last = (CNT_W'(j_q) == fill_q - CNT_W'(1));
	assign i_last = (CNT_W'(i_q) == fill_q - CNT_W'(1));
	assign lt_sum = lt_cnt_q + CNT_W'(other < cand);
	assign le_sum = le_cnt_q + CNT_W'(other <= cand);
	// candidate covers sorted places lt_sum .. le_sum-1
	assign found  = (state_q == MD_SCAN) && rd_vld_s1 && rd_last_s1
		&& (lt_sum <= rank) && (rank < le_sum);

	always_comb begin
		state_d = state_q;
		case (state_q)
			MD_IDLE: begin
				if (start) begin
					state_d = MD_SCAN;
				end
			end
			MD_SCAN: begin
				if (found) begin
					state_d = MD_IDLE;
				end
			end
			default: begin
				state_d = MD_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= MD_IDLE;
			slot_q     <= '0;
			fill_q     <= '0;
			i_q        <= '0;
			j_q        <= '0;
			rd_vld_s1  <= 1'b0;
			rd_last_s1 <= 1'b0;
			lt_cnt_q   <= '0;
			le_cnt_q   <= '0;
			median_q   <= '0;
			ok_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == MD_IDLE) begin
				rd_vld_s1 <= 1'b0;
				if (start) begin
					slot_q   <= (CNT_W'(slot_q) == CNT_W'(DEPTH - 1)) ? '0
						: slot_q + IDX_W'(1);
					if (fill_q != CNT_W'(DEPTH)) begin
						fill_q <= fill_q + CNT_W'(1);
					end
					i_q      <= '0;
					j_q      <= '0;
					lt_cnt_q <= '0;
					le_cnt_q <= '0;
				end
			end else begin
				// issue the next pair of reads
				rd_vld_s1  <= !found;
				rd_last_s1 <= j_last;
				if (j_last) begin
					j_q <= '0;
					if (!i_last) begin
						i_q <= i_q + IDX_W'(1);
					end
				end else begin
					j_q <= j_q + IDX_W'(1);
				end
				// count the pair read last cycle
				if (rd_vld_s1) begin
					if (rd_last_s1) begin
						lt_cnt_q <= '0;
						le_cnt_q <= '0;
					end else begin
						lt_cnt_q <= lt_sum;
						le_cnt_q <= le_sum;
					end
				end
				if (found) begin
					median_q <= cand;
					ok_q     <= 1'b1;
				end
			end
		end
	end

	assign status.busy  = (state_q == MD_SCAN);
	assign status.ok    = ok_q;
	assign status.value = median_q;

	`ERM_ASSERT_NOW(a_start_when_idle, start, state_q == MD_IDLE)
	`ERM_ASSERT_NOW(a_index_in_fill, state_q == MD_SCAN, CNT_W'(i_q) < fill_q)
	`ERM_ASSERT_NEXT(a_found_sets_ok, found, ok_q && state_q == MD_IDLE)

endmodule

`default_nettype wire

// ===== design/echo_ranging_median_filter.sv =====
// Echo ranging front end; median of the last DEPTH accepted distances.
// Depends on erm_pkg, erm_ranger, erm_median and the assertion macro header.
//
// Use: present one beat on the tick channel per microsecond (start_req and
// the sampled echo level). Every accepted tick gives exactly one beat on the
// result channel: the trigger level to drive, busy, done, and on a done beat
// the accepted flag and the measured distance in 1/16 cm, together with the
// current median distance and its valid flag.
// Latency: an ordinary tick's result is registered at the accept edge and is
// offered the next cycle; such ticks can be taken every cycle while no
// waiting result is stalled. A tick that ends an echo high phase passes the
// conversion state (one multiply), then, if the width is in the window, the
// median state, which waits for a search over the n filled entries (up to
// DEPTH) on the shared comparator pair, and last the emit state. tick_stall
// is high while this runs. While result_stall is high and a result waits,
// that result holds and no further tick is taken. Reset returns the state
// machine to idle, empties the sample ring and restores the register
// defaults; no clearing pass is needed.
// Registers (APB, byte address 4*i): echo timeout, minimum and maximum width
// in microseconds; write them only while the block is idle.
`default_nettype none
`include "echo_ranging_median_filter_defines.svh"

module echo_ranging_median_filter #(
	parameter int DEPTH = erm_pkg::DEPTH_DEFAULT
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        tick_valid,
	output logic                             tick_stall,
	input  wire erm_pkg::tick_t              tick,
	output logic                             result_valid,
	input  wire logic                        result_stall,
	output erm_pkg::result_t                 result,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [erm_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);

	import erm_pkg::*;

	logic [US_W-1:0] timeout_q, min_width_q, max_width_q;

	seq_state_t        seq_q, seq_d;
	logic [US_W-1:0]   width_q;
	logic              acc_q;
	logic [DIST_W-1:0] dist_q, dist_next;
	logic [PROD_W-1:0] prod;
	result_t           res_q, res_d;
	logic              out_valid_q;

	logic        res_free, res_load, tick_take, med_start, in_window;
	rng_out_t    rng;
	med_status_t med;

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= TIMEOUT_RESET;
			min_width_q <= MIN_WIDTH_RESET;
			max_width_q <= MAX_WIDTH_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_ECHO_TIMEOUT: timeout_q   <= pwdata[US_W-1:0];
				REG_MIN_WIDTH:    min_width_q <= pwdata[US_W-1:0];
				REG_MAX_WIDTH:    max_width_q <= pwdata[US_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_ECHO_TIMEOUT: prdata = 32'(timeout_q);
			REG_MIN_WIDTH:    prdata = 32'(min_width_q);
			REG_MAX_WIDTH:    prdata = 32'(max_width_q);
			default:          prdata = '0;
		endcase
	end

	// tick handshake
	assign res_free   = !out_valid_q || !result_stall;
	assign tick_stall = !((seq_q == SQ_READY) && res_free);
	assign tick_take  = tick_valid && !tick_stall;

	erm_ranger u_ranger (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (tick_take),
		.tick    (tick),
		.timeout (timeout_q),
		.rng     (rng)
	);

	assign in_window = (rng.width >= min_width_q) && (rng.width <= max_width_q);

	// width in us to 1/16 cm: (8 * width) / 29 by reciprocal multiply
	assign prod      = PROD_W'({width_q, 3'b000}) * PROD_W'(DIST_RECIP);
	assign dist_next = prod[RECIP_SH +: DIST_W];

	erm_median #(
		.DEPTH (DEPTH)
	) u_median (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (med_start),
		.sample (dist_next),
		.status (med)
	);

	always_comb begin
		seq_d     = seq_q;
		res_load  = 1'b0;
		med_start = 1'b0;
		res_d     = '0;
		res_d.filtered_distance = med.value;
		res_d.filtered_valid    = med.ok;
		case (seq_q)
			SQ_READY: begin
				if (tick_take) begin
					if (rng.measure) begin
						seq_d = SQ_CONV;
					end else begin
						res_load       = 1'b1;
						res_d.trigger  = rng.trigger;
						res_d.busy_res = rng.busy;
						res_d.done_res = rng.done;
					end
				end
			end
			SQ_CONV: begin
				med_start = acc_q;
				seq_d     = acc_q ? SQ_MED : SQ_EMIT;
			end
			SQ_MED: begin
				if (!med.busy) begin
					seq_d = SQ_EMIT;
				end
			end
			SQ_EMIT: begin
				if (res_free) begin
					res_load                = 1'b1;
					res_d.done_res          = 1'b1;
					res_d.accepted          = acc_q;
					res_d.measured_distance = dist_q;
					seq_d                   = SQ_READY;
				end
			end
			default: begin
				seq_d = SQ_READY;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q       <= SQ_READY;
			out_valid_q <= 1'b0;
			acc_q       <= 1'b0;
		end else begin
			seq_q <= seq_d;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
			if (tick_take && rng.measure) begin
				acc_q <= in_window;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick_take && rng.measure) begin
			width_q <= rng.width;
		end
		if (seq_q == SQ_CONV) begin
			dist_q <= dist_next;
		end
		if (res_load) begin
			res_q <= res_d;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = res_q;

	`ERM_ASSERT_NOW(a_median_only_in_med, med.busy, seq_q == SQ_MED)
	`ERM_ASSERT_NEXT(a_conv_single_cycle, seq_q == SQ_CONV, seq_q != SQ_CONV)
	`ERM_ASSERT_NEXT(a_emit_gives_done, seq_q == SQ_EMIT && res_free, out_valid_q && res_q.done_res)

endmodule

`default_nettype wire

// ===== tb/tb_echo_ranging_median_filter.sv =====
// Self-checking testbench for echo_ranging_median_filter: drives microsecond ticks and
// register writes, predicts every result beat in place and checks each one field by field.
// Depends on erm_pkg and the design sources only.
`default_nettype none

module tb_echo_ranging_median_filter;
	timeunit 1ns;
	timeprecision 1ps;

	import erm_pkg::*;

	localparam int RING_DEPTH = DEPTH_DEFAULT;
	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int PHASE_TICKS = 35;
	localparam int DIR_N = 13;

	typedef struct {
		tick_t   stim;
		int      reps;
		bit      typed;
		result_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic tick_valid = 1'b0;
	logic tick_stall;
	tick_t tick = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// predicted state of the block
	phase_t rng_phase;
	logic [US_W-1:0] rng_elapsed;
	logic [DIST_W-1:0] ring [RING_DEPTH];
	int ring_slot;
	int ring_fill;
	logic [DIST_W-1:0] med_value;
	logic med_ok;
	logic [US_W-1:0] cfg_regs [3];

	result_t pending_results [$];
	int fail_count = 0;
	int tick_items = 0;
	int cycles = 0;
	int stall_left = 0;
	bit burst_mode = 1'b0;
	dir_row_t dir_rows [DIR_N];

	echo_ranging_median_filter DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick_valid   (tick_valid),
		.tick_stall   (tick_stall),
		.tick         (tick),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	function automatic logic [DIST_W-1:0] ring_upper_median();
		logic [DIST_W-1:0] srt [RING_DEPTH];
		logic [DIST_W-1:0] key;
		int j;
		for (int i = 0; i < RING_DEPTH; i++)
			srt[i] = ring[i];
		for (int i = 1; i < ring_fill; i++) begin
			key = srt[i];
			j = i;
			while (j > 0 && srt[j-1] > key) begin
				srt[j] = srt[j-1];
				j--;
			end
			srt[j] = key;
		end
		return srt[ring_fill / 2];
	endfunction

	task automatic predict_tick(input tick_t t, output result_t r);
		logic [US_W-1:0] width;
		int dist_val;
		logic done;
		r = '0;
		done = 1'b0;
		case (rng_phase)
		PH_IDLE: begin
			if (t.start_req) begin
				rng_phase = PH_TRIG_LOW;
				rng_elapsed = 1;
				r.busy_res = 1'b1;
			end
		end
		PH_TRIG_LOW: begin
			r.busy_res = 1'b1;
			rng_elapsed++;
			if (rng_elapsed >= TRIG_LOW_TICKS) begin
				rng_phase = PH_TRIG_HIGH;
				rng_elapsed = 0;
			end
		end
		PH_TRIG_HIGH: begin
			r.trigger = 1'b1;
			r.busy_res = 1'b1;
			rng_elapsed++;
			if (rng_elapsed >= TRIG_HIGH_TICKS) begin
				rng_phase = PH_WAIT_RISE;
				rng_elapsed = 0;
			end
		end
		PH_WAIT_RISE: begin
			if (t.echo) begin
				if (cfg_regs[REG_ECHO_TIMEOUT] == 0) begin
					done = 1'b1;
				end else begin
					rng_phase = PH_HIGH;
					rng_elapsed = 1;
					r.busy_res = 1'b1;
				end
			end else if (rng_elapsed >= cfg_regs[REG_ECHO_TIMEOUT]) begin
				done = 1'b1;
			end else begin
				rng_elapsed++;
				r.busy_res = 1'b1;
			end
		end
		PH_HIGH: begin
			if (!t.echo) begin
				done = 1'b1;
				width = rng_elapsed;
				dist_val = (int'(width) * 16) / 58;
				r.measured_distance = dist_val[DIST_W-1:0];
				if (width >= cfg_regs[REG_MIN_WIDTH] && width <= cfg_regs[REG_MAX_WIDTH]) begin
					r.accepted = 1'b1;
					ring[ring_slot] = dist_val[DIST_W-1:0];
					ring_slot = (ring_slot + 1) % RING_DEPTH;
					if (ring_fill < RING_DEPTH)
						ring_fill++;
					med_value = ring_upper_median();
					med_ok = 1'b1;
				end
			end else if (rng_elapsed >= cfg_regs[REG_ECHO_TIMEOUT]) begin
				done = 1'b1;
			end else begin
				rng_elapsed++;
				r.busy_res = 1'b1;
			end
		end
		default: begin
			rng_phase = PH_IDLE;
			rng_elapsed = 0;
		end
		endcase
		if (done) begin
			rng_phase = PH_IDLE;
			rng_elapsed = 0;
		end
		r.done_res = done;
		r.filtered_distance = med_value;
		r.filtered_valid = med_ok;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// enter and leave at a falling edge
	task automatic send_tick(input tick_t t, input bit typed = 1'b0, input result_t want = '0);
		result_t r;
		int gap;
		gap = burst_mode ? 0 : pick_gap();
		if (gap > 0) begin
			tick_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		tick_valid <= 1'b1;
		tick <= t;
		do @(posedge clk); while (tick_stall);
		predict_tick(t, r);
		pending_results.push_back(typed ? want : r);
		tick_items++;
		@(negedge clk);
	endtask

	task automatic hold_until_drained();
		tick_valid <= 1'b0;
		do @(negedge clk); while (pending_results.size() != 0);
	endtask

	task automatic apb_access(input bit wr, input logic [1:0] idx, input logic [US_W-1:0] val);
		logic [31:0] word;
		word = $urandom;
		word[US_W-1:0] = val;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= word;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (wr)
			cfg_regs[idx] = val;
		else
			check_field("prdata", 32'(cfg_regs[idx]), prdata);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic program_window(input int t_out, input int w_min, input int w_max);
		hold_until_drained();
		// let any median search still in flight finish
		repeat (32) @(negedge clk);
		apb_access(1'b1, REG_ECHO_TIMEOUT, US_W'(t_out));
		apb_access(1'b1, REG_MIN_WIDTH, US_W'(w_min));
		apb_access(1'b1, REG_MAX_WIDTH, US_W'(w_max));
		apb_access(1'b0, REG_ECHO_TIMEOUT, '0);
		apb_access(1'b0, REG_MIN_WIDTH, '0);
		apb_access(1'b0, REG_MAX_WIDTH, '0);
	endtask

	// a measurement unless it times out: wait_lo low ticks before the rise, high_n high ticks
	task automatic run_echo(input int wait_lo, input int high_n);
		tick_t t;
		int lows;
		int highs;
		lows = 0;
		highs = 0;
		if (rng_phase == PH_IDLE) begin
			t.start_req = 1'b1;
			t.echo = 1'($urandom);
			send_tick(t);
		end
		while (rng_phase != PH_IDLE) begin
			t.start_req = 1'($urandom);
			t.echo = 1'($urandom);
			if (rng_phase == PH_WAIT_RISE) begin
				t.echo = (lows >= wait_lo);
				if (t.echo)
					highs = 1;
				else
					lows++;
			end else if (rng_phase == PH_HIGH) begin
				t.echo = (highs < high_n);
				if (t.echo)
					highs++;
			end
			send_tick(t);
		end
	endtask

	// finish whatever measurement noise has left open
	task automatic close_measurement();
		tick_t t;
		while (rng_phase != PH_IDLE) begin
			t.start_req = 1'($urandom);
			t.echo = (rng_phase == PH_WAIT_RISE);
			send_tick(t);
		end
	endtask

	function automatic int pick_wait(input int t_out);
		int c;
		case ($urandom_range(0, 9))
		0: c = t_out;
		1: c = t_out + 1;
		default: c = $urandom_range(0, 6);
		endcase
		if (c > 64)
			c = $urandom_range(0, 6);
		return c;
	endfunction

	function automatic int pick_width(input int t_out, input int w_min, input int w_max);
		int c;
		case ($urandom_range(0, 9))
		0: c = w_min - 1;
		1: c = w_min;
		2: c = w_max;
		3: c = w_max + 1;
		4: c = t_out;
		5: c = t_out + 1;
		default: c = $urandom_range(1, 40);
		endcase
		if (c < 1 || c > 64)
			c = $urandom_range(1, 40);
		return c;
	endfunction

	// receiver back-pressure
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else begin
			result_stall <= !burst_mode && ($urandom_range(0, 3) == 0);
			stall_left <= burst_mode ? 0 : pick_gap();
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				$error("result beat with no tick outstanding");
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("trigger", 32'(want.trigger), 32'(result.trigger));
				check_field("busy_res", 32'(want.busy_res), 32'(result.busy_res));
				check_field("done_res", 32'(want.done_res), 32'(result.done_res));
				check_field("accepted", 32'(want.accepted), 32'(result.accepted));
				check_field("measured_distance", 32'(want.measured_distance),
					32'(result.measured_distance));
				check_field("filtered_distance", 32'(want.filtered_distance),
					32'(result.filtered_distance));
				check_field("filtered_valid", 32'(want.filtered_valid),
					32'(result.filtered_valid));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int t_out;
		int w_min;
		int w_max;
		int base;
		int sel;
		logic [1:0] noise_bits;

		rng_phase = PH_IDLE;
		rng_elapsed = '0;
		ring_slot = 0;
		ring_fill = 0;
		med_value = '0;
		med_ok = 1'b0;
		cfg_regs[REG_ECHO_TIMEOUT] = TIMEOUT_RESET;
		cfg_regs[REG_MIN_WIDTH] = MIN_WIDTH_RESET;
		cfg_regs[REG_MAX_WIDTH] = MAX_WIDTH_RESET;
		for (int i = 0; i < RING_DEPTH; i++)
			ring[i] = '0;

		// trigger, busy, done, accepted, measured, filtered, filtered_valid
		dir_rows = '{
			'{'{1'b0, 1'b1}, 1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 14'd0, 14'd0, 1'b0}},
			'{'{1'b1, 1'b0}, 1, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b0, 14'd0, 14'd0, 1'b0}},
			'{'{1'b1, 1'b1}, 3, 1'b0, '0},
			'{'{1'b1, 1'b1}, 10, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 14'd0, 14'd0, 1'b0}},
			'{'{1'b0, 1'b0}, 5, 1'b0, '0},
			'{'{1'b1, 1'b1}, 116, 1'b0, '0},
			'{'{1'b1, 1'b0}, 1, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b1, 14'd32, 14'd32, 1'b1}},
			'{'{1'b0, 1'b0}, 1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 14'd0, 14'd32, 1'b1}},
			'{'{1'b1, 1'b0}, 1, 1'b0, '0},
			'{'{1'b0, 1'b1}, 13, 1'b0, '0},
			'{'{1'b0, 1'b1}, 115, 1'b0, '0},
			'{'{1'b0, 1'b0}, 1, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 14'd31, 14'd32, 1'b1}},
			'{'{1'b0, 1'b1}, 1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 14'd0, 14'd32, 1'b1}}
		};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIR_N; i++)
			for (int k = 0; k < dir_rows[i].reps; k++)
				send_tick(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);

		for (int p = 0; p < 8; p++) begin
			case (p)
			0: begin t_out = 40; w_min = 3; w_max = 30; end
			1: begin t_out = 0; w_min = 0; w_max = 32767; end
			2: begin t_out = 1; w_min = 1; w_max = 1; end
			3: begin t_out = 25; w_min = 20; w_max = 5; end
			4: begin t_out = 32767; w_min = 32767; w_max = 32767; end
			default: begin
				t_out = $urandom_range(1, 50);
				w_min = $urandom_range(0, 25);
				w_max = $urandom_range(5, 60);
			end
			endcase
			program_window(t_out, w_min, w_max);
			base = tick_items;
			while (tick_items - base < PHASE_TICKS) begin
				burst_mode = ($urandom_range(0, 4) == 0);
				sel = $urandom_range(0, 19);
				if (sel == 0) begin
					hold_until_drained();
				end else if (sel < 4) begin
					repeat ($urandom_range(1, 6)) begin
						noise_bits = 2'($urandom);
						send_tick(noise_bits);
					end
					close_measurement();
				end else begin
					run_echo(pick_wait(t_out), pick_width(t_out, w_min, w_max));
				end
			end
		end

		burst_mode = 1'b0;
		tick_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire
